// ----- hw/rtl/dtcr_pkg.sv -----
`timescale 1ns / 1ps
package dtcr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEPTH_BITS = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_INTR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_INTR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XFORM_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XFORM_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_XFORM_Z     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_W     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_H     = 3'd7;

  localparam logic [15:0] SCALE_RST   = 16'd66;
  localparam logic [12:0] COLOR_W_RST = 13'd640;
  localparam logic [12:0] COLOR_H_RST = 13'd480;

  // divider: quotient bits, divisor bits, bits retired per stage
  localparam int DIV_Q_W      = 32;
  localparam int DIV_DEN_W    = 36;
  localparam int DIV_NUM_W    = DIV_Q_W + DIV_DEN_W;
  localparam int DIV_STEPS    = 2;
  localparam int DIV_STAGES   = DIV_Q_W / DIV_STEPS;
  localparam int DIV_LAT      = DIV_STAGES + 1;

  localparam int D_W     = 32;
  localparam int DIFF_W  = 20;
  localparam int NUM_A_W = D_W + DIFF_W;
  localparam int P_W     = 32;
  localparam int PROD_W  = 48;
  localparam int SUM_W   = 49;
  localparam int ACC_W   = 50;
  localparam int Q_W     = 36;
  localparam int NUM_B_W = 52;
  localparam int TOFF_W  = 33;
  localparam int U4_W    = 19;

  // t * 2^30 / 10000 = 107374 * t + (114 * t) / 625
  localparam logic [16:0] TOFF_MUL_HI = 17'd107374;
  localparam logic [6:0]  TOFF_MUL_LO = 7'd114;
  localparam logic [22:0] TOFF_RECIP  = 23'd6871948;

  localparam logic signed [P_W-1:0] P_MAX = 32'sh7fffffff;
  localparam logic signed [P_W-1:0] P_MIN = 32'sh80000000;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [DEPTH_BITS-1:0] raw_depth;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [11:0]        color_col;
    logic [11:0]        color_row;
    logic               has_depth;
    logic               in_color_view;
  } out_item_t;

endpackage

// ----- hw/rtl/depth_to_color_registration.sv -----
`timescale 1ns / 1ps
// Throughput: one transaction per cycle outside reset, set by the fully pipelined datapath
// and the four 17-stage dividers (two for deprojection, two for projection), whose
// stages after the input register each retire two quotient bits.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
// busy is high only during reset; the receiver cannot stall, so the pipeline never holds.
module depth_to_color_registration (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  dtcr_pkg::in_item_t                 in_data,
  output logic                               out_strobe,
  output dtcr_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [dtcr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [dtcr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef struct packed {
    logic                        valid;
    logic                        has;
    logic                        negx;
    logic                        negy;
    logic                        fxz;
    logic                        fyz;
    logic [dtcr_pkg::D_W-1:0]    d;
  } sba_t;

  typedef struct packed {
    logic                        valid;
    logic                        has;
    logic signed [31:0]          posx;
    logic signed [31:0]          posy;
    logic signed [31:0]          posz;
    logic                        negu;
    logic                        negv;
    logic                        qzpos;
  } sbb_t;

  // configuration
  logic [63:0] dintr_r, dintr_nxt;
  logic [63:0] cintr_r, cintr_nxt;
  logic [63:0] xrow_r [0:2];
  logic [63:0] xrow_nxt [0:2];
  logic [15:0] scale_r, scale_nxt;
  logic [12:0] cw_r, cw_nxt;
  logic [12:0] ch_r, ch_nxt;

  always_comb begin
    dintr_nxt = dintr_r;
    cintr_nxt = cintr_r;
    for (int i = 0; i < 3; i++) xrow_nxt[i] = xrow_r[i];
    scale_nxt = scale_r;
    cw_nxt    = cw_r;
    ch_nxt    = ch_r;
    if (cfg_we) begin
      case (cfg_idx)
        dtcr_pkg::REG_DEPTH_INTR:  dintr_nxt   = cfg_wdata;
        dtcr_pkg::REG_COLOR_INTR:  cintr_nxt   = cfg_wdata;
        dtcr_pkg::REG_XFORM_X:     xrow_nxt[0] = cfg_wdata;
        dtcr_pkg::REG_XFORM_Y:     xrow_nxt[1] = cfg_wdata;
        dtcr_pkg::REG_XFORM_Z:     xrow_nxt[2] = cfg_wdata;
        dtcr_pkg::REG_DEPTH_SCALE: scale_nxt   = cfg_wdata[15:0];
        dtcr_pkg::REG_COLOR_W:     cw_nxt      = cfg_wdata[12:0];
        dtcr_pkg::REG_COLOR_H:     ch_nxt      = cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dintr_r <= '0;
      cintr_r <= '0;
      for (int i = 0; i < 3; i++) xrow_r[i] <= '0;
      scale_r <= dtcr_pkg::SCALE_RST;
      cw_r    <= dtcr_pkg::COLOR_W_RST;
      ch_r    <= dtcr_pkg::COLOR_H_RST;
    end else begin
      dintr_r <= dintr_nxt;
      cintr_r <= cintr_nxt;
      for (int i = 0; i < 3; i++) xrow_r[i] <= xrow_nxt[i];
      scale_r <= scale_nxt;
      cw_r    <= cw_nxt;
      ch_r    <= ch_nxt;
    end
  end

  logic [15:0] dfx, dfy, dcx, dcy, cfx, cfy, ccx, ccy;
  assign dfx = dintr_r[15:0];
  assign dfy = dintr_r[31:16];
  assign dcx = dintr_r[47:32];
  assign dcy = dintr_r[63:48];
  assign cfx = cintr_r[15:0];
  assign cfy = cintr_r[31:16];
  assign ccx = cintr_r[47:32];
  assign ccy = cintr_r[63:48];

  function automatic logic [44:0] tob_dummy(input logic [21:0] y);
    tob_dummy = 45'(y) * 45'(dtcr_pkg::TOFF_RECIP);
  endfunction

  // translation offsets in Q.30, derived from the transform rows
  logic                              toa_neg_r [0:2];
  logic [31:0]                       toa_hi_r  [0:2];
  logic [21:0]                       toa_lo_r  [0:2];
  logic                              tob_neg_r [0:2];
  logic [31:0]                       tob_hi_r  [0:2];
  logic [12:0]                       tob_lo_r  [0:2];
  logic signed [dtcr_pkg::TOFF_W-1:0] toff_r   [0:2];

  always_ff @(posedge clk) begin
    logic [15:0] ta;
    logic [44:0] lp;
    for (int i = 0; i < 3; i++) begin
      ta = xrow_r[i][63] ? 16'(-xrow_r[i][63:48]) : xrow_r[i][63:48];
      lp = 45'(tob_dummy(toa_lo_r[i]));
      toa_neg_r[i] <= xrow_r[i][63];
      toa_hi_r[i]  <= 32'(ta) * 32'(dtcr_pkg::TOFF_MUL_HI);
      toa_lo_r[i]  <= 22'(ta) * 22'(dtcr_pkg::TOFF_MUL_LO);
      tob_neg_r[i] <= toa_neg_r[i];
      tob_hi_r[i]  <= toa_hi_r[i];
      tob_lo_r[i]  <= lp[44:32];
      toff_r[i]    <= tob_neg_r[i] ?
                      -$signed({1'b0, tob_hi_r[i] + 32'(tob_lo_r[i])}) :
                       $signed({1'b0, tob_hi_r[i] + 32'(tob_lo_r[i])});
    end
  end

  function automatic logic signed [31:0] sat_p(input logic zf, input logic neg,
                                               input logic ovf,
                                               input logic [dtcr_pkg::DIV_Q_W-1:0] q);
    logic signed [31:0] r;
    if (zf) begin
      r = '0;
    end else if (ovf || q[dtcr_pkg::DIV_Q_W-1]) begin
      r = neg ? dtcr_pkg::P_MIN : dtcr_pkg::P_MAX;
    end else begin
      r = neg ? -$signed(q) : $signed(q);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] p);
    return (p == dtcr_pkg::P_MIN) ? dtcr_pkg::P_MAX : -p;
  endfunction

  assign busy = !rst_n;

  // stage 1: input capture
  logic                            s1_v_r;
  logic [dtcr_pkg::COORD_BITS-1:0] s1_col_r, s1_row_r;
  logic [dtcr_pkg::DEPTH_BITS-1:0] s1_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= start && !busy;
    s1_col_r <= in_data.pixel_col;
    s1_row_r <= in_data.pixel_row;
    s1_raw_r <= in_data.raw_depth;
  end

  // stage 2: scale depth, center offsets
  logic                        s2_v_r;
  logic                        s2_has_r;
  logic [dtcr_pkg::D_W-1:0]    s2_d_r;
  logic [dtcr_pkg::DIFF_W-1:0] s2_magx_r, s2_magy_r;
  logic                        s2_negx_r, s2_negy_r;

  always_ff @(posedge clk) begin
    logic signed [dtcr_pkg::DIFF_W-1:0] ox, oy;
    ox = $signed(dtcr_pkg::DIFF_W'({s1_col_r, 4'b0000})) - $signed(dtcr_pkg::DIFF_W'(dcx));
    oy = $signed(dtcr_pkg::DIFF_W'({s1_row_r, 4'b0000})) - $signed(dtcr_pkg::DIFF_W'(dcy));
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
    s2_has_r  <= s1_raw_r != '0;
    s2_d_r    <= dtcr_pkg::D_W'(s1_raw_r) * dtcr_pkg::D_W'(scale_r);
    s2_negx_r <= ox[dtcr_pkg::DIFF_W-1];
    s2_negy_r <= oy[dtcr_pkg::DIFF_W-1];
    s2_magx_r <= ox[dtcr_pkg::DIFF_W-1] ? dtcr_pkg::DIFF_W'(-ox) : dtcr_pkg::DIFF_W'(ox);
    s2_magy_r <= oy[dtcr_pkg::DIFF_W-1] ? dtcr_pkg::DIFF_W'(-oy) : dtcr_pkg::DIFF_W'(oy);
  end

  // stage 3: numerators for deprojection
  sba_t                          s3_sb_r;
  logic [dtcr_pkg::NUM_A_W-1:0]  s3_numx_r, s3_numy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_sb_r.valid <= 1'b0;
    else        s3_sb_r.valid <= s2_v_r;
    s3_sb_r.has  <= s2_has_r;
    s3_sb_r.negx <= s2_negx_r;
    s3_sb_r.negy <= s2_negy_r;
    s3_sb_r.fxz  <= dfx == '0;
    s3_sb_r.fyz  <= dfy == '0;
    s3_sb_r.d    <= s2_d_r;
    s3_numx_r    <= dtcr_pkg::NUM_A_W'(s2_d_r) * dtcr_pkg::NUM_A_W'(s2_magx_r);
    s3_numy_r    <= dtcr_pkg::NUM_A_W'(s2_d_r) * dtcr_pkg::NUM_A_W'(s2_magy_r);
  end

  logic [dtcr_pkg::DIV_Q_W-1:0] qx_div, qy_div;
  logic                         ox_div, oy_div;

  dtcr_div u_div_px (
    .clk   (clk),
    .num_i (dtcr_pkg::DIV_NUM_W'(s3_numx_r)),
    .den_i (dtcr_pkg::DIV_DEN_W'(dfx)),
    .quo_o (qx_div),
    .ovf_o (ox_div)
  );

  dtcr_div u_div_py (
    .clk   (clk),
    .num_i (dtcr_pkg::DIV_NUM_W'(s3_numy_r)),
    .den_i (dtcr_pkg::DIV_DEN_W'(dfy)),
    .quo_o (qy_div),
    .ovf_o (oy_div)
  );

  sba_t sba_r [0:dtcr_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    sba_t sba_nxt;
    sba_nxt = s3_sb_r;
    if (!rst_n) sba_nxt.valid = 1'b0;
    sba_r[0] <= sba_nxt;
    for (int k = 1; k < dtcr_pkg::DIV_LAT; k++) begin
      sba_nxt = sba_r[k-1];
      if (!rst_n) sba_nxt.valid = 1'b0;
      sba_r[k] <= sba_nxt;
    end
  end

  // stage 4: point and negated output point
  sba_t               sbo;
  logic               s4_v_r, s4_has_r;
  logic signed [31:0] s4_p_r   [0:2];
  logic signed [31:0] s4_pos_r [0:2];

  assign sbo = sba_r[dtcr_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    logic signed [31:0] px, py, pz;
    px = sat_p(sbo.fxz, sbo.negx, ox_div, qx_div);
    py = sat_p(sbo.fyz, sbo.negy, oy_div, qy_div);
    pz = sbo.d[dtcr_pkg::D_W-1] ? dtcr_pkg::P_MAX : $signed(sbo.d);
    if (!rst_n) s4_v_r <= 1'b0;
    else        s4_v_r <= sbo.valid;
    s4_has_r    <= sbo.has;
    s4_p_r[0]   <= px;
    s4_p_r[1]   <= py;
    s4_p_r[2]   <= pz;
    s4_pos_r[0] <= neg_sat(px);
    s4_pos_r[1] <= neg_sat(py);
    s4_pos_r[2] <= neg_sat(pz);
  end

  // stages 5..8: rigid transform
  logic                                s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic                                s5_has_r, s6_has_r, s7_has_r, s8_has_r;
  logic signed [31:0]                  s5_pos_r [0:2];
  logic signed [31:0]                  s6_pos_r [0:2];
  logic signed [31:0]                  s7_pos_r [0:2];
  logic signed [31:0]                  s8_pos_r [0:2];
  logic signed [dtcr_pkg::PROD_W-1:0]  s5_prod_r [0:2][0:2];
  logic signed [dtcr_pkg::SUM_W-1:0]   s6_sa_r [0:2];
  logic signed [dtcr_pkg::SUM_W-1:0]   s6_sb_r [0:2];
  logic signed [dtcr_pkg::ACC_W-1:0]   s7_acc_r [0:2];
  logic signed [dtcr_pkg::Q_W-1:0]     s8_q_r [0:2];

  always_ff @(posedge clk) begin
    logic signed [dtcr_pkg::ACC_W-1:0] rnd;
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
    s5_has_r <= s4_has_r;
    s6_has_r <= s5_has_r;
    s7_has_r <= s6_has_r;
    s8_has_r <= s7_has_r;
    for (int i = 0; i < 3; i++) begin
      s5_pos_r[i] <= s4_pos_r[i];
      s6_pos_r[i] <= s5_pos_r[i];
      s7_pos_r[i] <= s6_pos_r[i];
      s8_pos_r[i] <= s7_pos_r[i];
      for (int j = 0; j < 3; j++) begin
        s5_prod_r[i][j] <= $signed(xrow_r[i][16*j +: 16]) * s4_p_r[j];
      end
      s6_sa_r[i]  <= dtcr_pkg::SUM_W'(s5_prod_r[i][0]) + dtcr_pkg::SUM_W'(s5_prod_r[i][1]);
      s6_sb_r[i]  <= dtcr_pkg::SUM_W'(s5_prod_r[i][2]) + dtcr_pkg::SUM_W'(toff_r[i]);
      s7_acc_r[i] <= dtcr_pkg::ACC_W'(s6_sa_r[i]) + dtcr_pkg::ACC_W'(s6_sb_r[i]);
      // divide by 2^14 toward zero
      rnd = s7_acc_r[i] + $signed({{(dtcr_pkg::ACC_W-14){1'b0}},
                                   {14{s7_acc_r[i][dtcr_pkg::ACC_W-1]}}});
      s8_q_r[i] <= rnd[dtcr_pkg::ACC_W-1:14];
    end
  end

  // stage 9: projection numerators
  sbb_t                          s9_sb_r;
  logic [dtcr_pkg::NUM_B_W-1:0]  s9_numu_r, s9_numv_r;
  logic [dtcr_pkg::Q_W-1:0]      s9_den_r;

  always_ff @(posedge clk) begin
    logic [dtcr_pkg::Q_W-1:0] ax, ay;
    ax = s8_q_r[0][dtcr_pkg::Q_W-1] ? dtcr_pkg::Q_W'(-s8_q_r[0]) : dtcr_pkg::Q_W'(s8_q_r[0]);
    ay = s8_q_r[1][dtcr_pkg::Q_W-1] ? dtcr_pkg::Q_W'(-s8_q_r[1]) : dtcr_pkg::Q_W'(s8_q_r[1]);
    if (!rst_n) s9_sb_r.valid <= 1'b0;
    else        s9_sb_r.valid <= s8_v_r;
    s9_sb_r.has   <= s8_has_r;
    s9_sb_r.posx  <= s8_pos_r[0];
    s9_sb_r.posy  <= s8_pos_r[1];
    s9_sb_r.posz  <= s8_pos_r[2];
    s9_sb_r.negu  <= s8_q_r[0][dtcr_pkg::Q_W-1];
    s9_sb_r.negv  <= s8_q_r[1][dtcr_pkg::Q_W-1];
    s9_sb_r.qzpos <= !s8_q_r[2][dtcr_pkg::Q_W-1] && (s8_q_r[2] != '0);
    s9_numu_r     <= dtcr_pkg::NUM_B_W'(ax) * dtcr_pkg::NUM_B_W'(cfx);
    s9_numv_r     <= dtcr_pkg::NUM_B_W'(ay) * dtcr_pkg::NUM_B_W'(cfy);
    s9_den_r      <= dtcr_pkg::Q_W'(s8_q_r[2]);
  end

  logic [dtcr_pkg::DIV_Q_W-1:0] qu_div, qv_div;
  logic                         ou_div, ov_div;

  dtcr_div u_div_pu (
    .clk   (clk),
    .num_i (dtcr_pkg::DIV_NUM_W'(s9_numu_r)),
    .den_i (dtcr_pkg::DIV_DEN_W'(s9_den_r)),
    .quo_o (qu_div),
    .ovf_o (ou_div)
  );

  dtcr_div u_div_pv (
    .clk   (clk),
    .num_i (dtcr_pkg::DIV_NUM_W'(s9_numv_r)),
    .den_i (dtcr_pkg::DIV_DEN_W'(s9_den_r)),
    .quo_o (qv_div),
    .ovf_o (ov_div)
  );

  sbb_t sbb_r [0:dtcr_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    sbb_t sbb_nxt;
    sbb_nxt = s9_sb_r;
    if (!rst_n) sbb_nxt.valid = 1'b0;
    sbb_r[0] <= sbb_nxt;
    for (int k = 1; k < dtcr_pkg::DIV_LAT; k++) begin
      sbb_nxt = sbb_r[k-1];
      if (!rst_n) sbb_nxt.valid = 1'b0;
      sbb_r[k] <= sbb_nxt;
    end
  end

  // stage 10: add color center
  sbb_t                             s10_sb_r;
  logic                             s10_oku_r, s10_okv_r;
  logic signed [dtcr_pkg::U4_W-1:0] s10_u4_r, s10_v4_r;
  sbb_t                             sbp;

  assign sbp = sbb_r[dtcr_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    logic signed [17:0] tu, tv;
    sbb_t               s10_sb_nxt;
    tu = sbp.negu ? -$signed({1'b0, qu_div[16:0]}) : $signed({1'b0, qu_div[16:0]});
    tv = sbp.negv ? -$signed({1'b0, qv_div[16:0]}) : $signed({1'b0, qv_div[16:0]});
    s10_sb_nxt = sbp;
    if (!rst_n) s10_sb_nxt.valid = 1'b0;
    s10_sb_r  <= s10_sb_nxt;
    s10_oku_r <= !ou_div && (qu_div[dtcr_pkg::DIV_Q_W-1:17] == '0);
    s10_okv_r <= !ov_div && (qv_div[dtcr_pkg::DIV_Q_W-1:17] == '0);
    s10_u4_r  <= dtcr_pkg::U4_W'(tu) + $signed(dtcr_pkg::U4_W'(ccx));
    s10_v4_r  <= dtcr_pkg::U4_W'(tv) + $signed(dtcr_pkg::U4_W'(ccy));
  end

  // stage 11: pixel, bounds, output register
  logic                out_strobe_r;
  dtcr_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    logic [13:0] u, v;
    logic        oku, okv, view;
    if (s10_u4_r[dtcr_pkg::U4_W-1]) begin
      u   = '0;
      oku = s10_u4_r > -19'sd16;
    end else begin
      u   = s10_u4_r[17:4];
      oku = 1'b1;
    end
    if (s10_v4_r[dtcr_pkg::U4_W-1]) begin
      v   = '0;
      okv = s10_v4_r > -19'sd16;
    end else begin
      v   = s10_v4_r[17:4];
      okv = 1'b1;
    end
    view = s10_sb_r.has && s10_sb_r.qzpos && s10_oku_r && s10_okv_r && oku && okv &&
           (u[13:12] == 2'b00) && (v[13:12] == 2'b00) &&
           (u < 14'(cw_r)) && (v < 14'(ch_r));
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= s10_sb_r.valid;
    out_data_r.pos_x         <= s10_sb_r.has ? s10_sb_r.posx : '0;
    out_data_r.pos_y         <= s10_sb_r.has ? s10_sb_r.posy : '0;
    out_data_r.pos_z         <= s10_sb_r.has ? s10_sb_r.posz : '0;
    out_data_r.color_col     <= view ? u[11:0] : '0;
    out_data_r.color_row     <= view ? v[11:0] : '0;
    out_data_r.has_depth     <= s10_sb_r.has;
    out_data_r.in_color_view <= view;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ----- hw/rtl/dtcr_div.sv -----
`timescale 1ns / 1ps
module dtcr_div (
  input  logic                              clk,
  input  logic [dtcr_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [dtcr_pkg::DIV_DEN_W-1:0]    den_i,
  output logic [dtcr_pkg::DIV_Q_W-1:0]      quo_o,
  output logic                              ovf_o
);

  logic [dtcr_pkg::DIV_DEN_W-1:0] rem_r   [0:dtcr_pkg::DIV_STAGES];
  logic [dtcr_pkg::DIV_DEN_W-1:0] rem_nxt [0:dtcr_pkg::DIV_STAGES];
  logic [dtcr_pkg::DIV_Q_W-1:0]   bits_r  [0:dtcr_pkg::DIV_STAGES];
  logic [dtcr_pkg::DIV_Q_W-1:0]   bits_nxt[0:dtcr_pkg::DIV_STAGES];
  logic [dtcr_pkg::DIV_DEN_W-1:0] den_r   [0:dtcr_pkg::DIV_STAGES];
  logic [dtcr_pkg::DIV_DEN_W-1:0] den_nxt [0:dtcr_pkg::DIV_STAGES];
  logic                           ovf_r   [0:dtcr_pkg::DIV_STAGES];
  logic                           ovf_nxt [0:dtcr_pkg::DIV_STAGES];

  always_comb begin
    logic [dtcr_pkg::DIV_DEN_W-1:0] rem;
    logic [dtcr_pkg::DIV_Q_W-1:0]   bits;
    logic [dtcr_pkg::DIV_DEN_W:0]   trial;
    rem_nxt[0]  = num_i[dtcr_pkg::DIV_NUM_W-1 -: dtcr_pkg::DIV_DEN_W];
    bits_nxt[0] = num_i[dtcr_pkg::DIV_Q_W-1:0];
    den_nxt[0]  = den_i;
    ovf_nxt[0]  = num_i >= {den_i, {dtcr_pkg::DIV_Q_W{1'b0}}};
    for (int k = 1; k <= dtcr_pkg::DIV_STAGES; k++) begin
      rem  = rem_r[k-1];
      bits = bits_r[k-1];
      for (int j = 0; j < dtcr_pkg::DIV_STEPS; j++) begin
        trial = {rem, bits[dtcr_pkg::DIV_Q_W-1]};
        bits  = {bits[dtcr_pkg::DIV_Q_W-2:0], 1'b0};
        if (trial >= {1'b0, den_r[k-1]}) begin
          trial   = trial - {1'b0, den_r[k-1]};
          bits[0] = 1'b1;
        end
        rem = trial[dtcr_pkg::DIV_DEN_W-1:0];
      end
      rem_nxt[k]  = rem;
      bits_nxt[k] = bits;
      den_nxt[k]  = den_r[k-1];
      ovf_nxt[k]  = ovf_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= dtcr_pkg::DIV_STAGES; k++) begin
      rem_r[k]  <= rem_nxt[k];
      bits_r[k] <= bits_nxt[k];
      den_r[k]  <= den_nxt[k];
      ovf_r[k]  <= ovf_nxt[k];
    end
  end

  assign quo_o = bits_r[dtcr_pkg::DIV_STAGES];
  assign ovf_o = ovf_r[dtcr_pkg::DIV_STAGES];

endmodule

// ----- dv/registration_checker.sv -----
`timescale 1ns / 1ps
module registration_checker
  import dtcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_data,
  input  logic                  out_strobe,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    errors
);

  logic [63:0] depth_intr, color_intr, row_x, row_y, row_z;
  logic [15:0] scale;
  logic [12:0] color_w, color_h;
  out_item_t   expected_pixels[$];

  assign pending = expected_pixels.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint deproject(longint d, longint coord, longint c, longint f);
    if (f == 0) return 0;
    return clamp32(d * (coord * 16 - c) / f);
  endfunction

  function automatic longint rotate_row(logic [63:0] r, longint p0, longint p1,
                                        longint p2);
    longint acc;
    acc = longint'($signed(r[15:0])) * p0 + longint'($signed(r[31:16])) * p1 +
          longint'($signed(r[47:32])) * p2;
    acc += longint'($signed(r[63:48])) * 64'sd1073741824 / 10000;
    return acc / 16384;
  endfunction

  function automatic out_item_t predict_pixel(in_item_t px);
    out_item_t o;
    longint d, p0, p1, p2, qx, qy, qz, u, v;
    o = '0;
    if (px.raw_depth == 0) return o;
    d  = longint'(px.raw_depth) * longint'(scale);
    p0 = deproject(d, longint'(px.pixel_col), longint'(depth_intr[47:32]),
                   longint'(depth_intr[15:0]));
    p1 = deproject(d, longint'(px.pixel_row), longint'(depth_intr[63:48]),
                   longint'(depth_intr[31:16]));
    p2 = clamp32(d);
    o.pos_x = 32'(clamp32(-p0));
    o.pos_y = 32'(clamp32(-p1));
    o.pos_z = 32'(clamp32(-p2));
    o.has_depth = 1'b1;
    qx = rotate_row(row_x, p0, p1, p2);
    qy = rotate_row(row_y, p0, p1, p2);
    qz = rotate_row(row_z, p0, p1, p2);
    if (qz > 0) begin
      u = (qx * longint'(color_intr[15:0]) / qz + longint'(color_intr[47:32])) / 16;
      v = (qy * longint'(color_intr[31:16]) / qz + longint'(color_intr[63:48])) / 16;
      if (u >= 0 && v >= 0 && u < longint'(color_w) && v < longint'(color_h) &&
          u < 4096 && v < 4096) begin
        o.in_color_view = 1'b1;
        o.color_col = 12'(u);
        o.color_row = 12'(v);
      end
    end
    return o;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      depth_intr <= '0;
      color_intr <= '0;
      row_x      <= '0;
      row_y      <= '0;
      row_z      <= '0;
      scale      <= SCALE_RST;
      color_w    <= COLOR_W_RST;
      color_h    <= COLOR_H_RST;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DEPTH_INTR:  depth_intr <= cfg_wdata;
          REG_COLOR_INTR:  color_intr <= cfg_wdata;
          REG_XFORM_X:     row_x <= cfg_wdata;
          REG_XFORM_Y:     row_y <= cfg_wdata;
          REG_XFORM_Z:     row_z <= cfg_wdata;
          REG_DEPTH_SCALE: scale <= cfg_wdata[15:0];
          REG_COLOR_W:     color_w <= cfg_wdata[12:0];
          REG_COLOR_H:     color_h <= cfg_wdata[12:0];
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $time, out_data);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          check_field("pos_x", e.pos_x, out_data.pos_x);
          check_field("pos_y", e.pos_y, out_data.pos_y);
          check_field("pos_z", e.pos_z, out_data.pos_z);
          check_field("color_col", e.color_col, out_data.color_col);
          check_field("color_row", e.color_row, out_data.color_row);
          check_field("has_depth", e.has_depth, out_data.has_depth);
          check_field("in_color_view", e.in_color_view, out_data.in_color_view);
        end
      end
      if (start && !busy) expected_pixels.push_back(predict_pixel(in_data));
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import dtcr_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_strobe;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    pending;
  int                    errors;
  int                    idle_pct;

  depth_to_color_registration i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  registration_checker u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata), .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] pack4(int a, int b, int c, int d);
    return {16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stop driving, let the pipeline empty out
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_pixel(int col, int row, int raw);
    in_item_t px;
    px.pixel_col = 12'(col);
    px.pixel_row = 12'(row);
    px.raw_depth = 16'(raw);
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic send_random(int n);
    int raw;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(7);
      if (sel == 0) raw = 0;
      else if (sel == 1) raw = $urandom_range(65535);
      else raw = $urandom_range(8000, 200);
      send_pixel($urandom_range(4095), $urandom_range(4095), raw);
    end
  endtask

  task automatic camera_setup(int tx, int ty, int tz);
    write_reg(REG_DEPTH_INTR, pack4(500 * 16, 500 * 16, 320 * 16, 240 * 16));
    write_reg(REG_COLOR_INTR, pack4(520 * 16, 515 * 16, 330 * 16, 250 * 16));
    write_reg(REG_XFORM_X, pack4(16384, 0, 0, tx));
    write_reg(REG_XFORM_Y, pack4(0, 16384, 0, ty));
    write_reg(REG_XFORM_Z, pack4(0, 0, 16384, tz));
    write_reg(REG_DEPTH_SCALE, 66);
    write_reg(REG_COLOR_W, 640);
    write_reg(REG_COLOR_H, 480);
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    idle_pct  = 22;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero intrinsics and transform
    send_pixel(0, 0, 0);
    send_pixel(4095, 4095, 65535);
    send_pixel(100, 200, 1);
    drain();

    camera_setup(250, -30, 40);
    send_pixel(320, 240, 1000);
    send_pixel(0, 0, 1500);
    send_pixel(4095, 0, 3000);
    send_pixel(0, 4095, 65535);
    send_pixel(4095, 4095, 65535);
    send_pixel(639, 479, 2000);
    send_pixel(320, 240, 0);
    send_pixel(2048, 2048, 32768);
    send_random(140);
    drain();

    // zero scale, zero color size
    write_reg(REG_DEPTH_SCALE, 0);
    send_pixel(320, 240, 5000);
    drain();
    write_reg(REG_DEPTH_SCALE, 16'hffff);
    write_reg(REG_COLOR_W, 0);
    write_reg(REG_COLOR_H, 0);
    send_pixel(320, 240, 1000);
    send_pixel(100, 50, 65535);
    send_random(140);
    drain();

    // point behind the color camera, zero depth focal lengths
    write_reg(REG_XFORM_Z, pack4(0, 0, -16384, -32768));
    write_reg(REG_COLOR_W, 4096);
    write_reg(REG_COLOR_H, 4096);
    write_reg(REG_DEPTH_INTR, pack4(0, 0, 320 * 16, 240 * 16));
    send_pixel(320, 240, 1000);
    send_pixel(10, 20, 4000);
    drain();

    idle_pct = 70;
    camera_setup(-400, 120, 32767);
    write_reg(REG_COLOR_W, 13'h1fff);
    write_reg(REG_COLOR_H, 1);
    send_random(60);
    // wait for everything in flight mid-stream
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    send_random(80);
    drain();

    for (int k = 0; k < 8; k++) write_reg(3'(k), {$urandom, $urandom});
    send_random(150);
    drain();

    idle_pct = 0;
    write_reg(REG_DEPTH_INTR, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_COLOR_INTR, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_XFORM_X, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_XFORM_Y, 64'h7fff_7fff_7fff_7fff);
    write_reg(REG_XFORM_Z, 64'h8000_7fff_8000_7fff);
    write_reg(REG_DEPTH_SCALE, 16'hffff);
    send_random(100);
    drain();

    camera_setup(0, 0, 0);
    write_reg(REG_XFORM_X, pack4(16000, -1200, 300, 500));
    write_reg(REG_XFORM_Z, pack4(-300, 200, 16300, 100));
    write_reg(REG_DEPTH_SCALE, 1000);
    send_random(220);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
